>>> rtl/qapm_pkg.sv
// ----------------------------------------------------------------------------
// qapm_pkg: quadrotor attitude PD mixer package
// Shared widths, register indexes, axis codes, reset values and beat types.
// ----------------------------------------------------------------------------
package qapm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 10;
  localparam int DEADBAND_W = 20;
  localparam int HOVER_W    = 39;
  localparam int THRUST_W   = 40;
  localparam int MOTOR_W    = 40;

  // error is one bit wider than a sample; correction holds gain * error sums
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int CORR_W     = SAMPLE_W + GAIN_W + 2;
  localparam int FORCE_W    = THRUST_W + 1;
  localparam int MIX_W      = FORCE_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = HOVER_W;

  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_KP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_KD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_KP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_KD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOVER    = 3'd7;

  localparam logic [GAIN_W-1:0]     RST_ROLL_KP  = 10'd135;
  localparam logic [GAIN_W-1:0]     RST_ROLL_KD  = 10'd105;
  localparam logic [GAIN_W-1:0]     RST_PITCH_KP = 10'd135;
  localparam logic [GAIN_W-1:0]     RST_PITCH_KD = 10'd105;
  localparam logic [GAIN_W-1:0]     RST_YAW_KP   = 10'd60;
  localparam logic [GAIN_W-1:0]     RST_YAW_KD   = 10'd95;
  localparam logic [DEADBAND_W-1:0] RST_DEADBAND = 20'd11;
  localparam logic [HOVER_W-1:0]    RST_HOVER    = 39'd0;

  typedef struct packed {
    logic [1:0]                 axis;
    logic signed [SAMPLE_W-1:0] desired_angle;
    logic signed [SAMPLE_W-1:0] measured_angle;
    logic signed [SAMPLE_W-1:0] desired_rate;
    logic signed [SAMPLE_W-1:0] measured_rate;
    logic signed [THRUST_W-1:0] thrust_delta;
  } in_t;

  typedef struct packed {
    logic signed [MOTOR_W-1:0] motor_0_speed;
    logic signed [MOTOR_W-1:0] motor_1_speed;
    logic signed [MOTOR_W-1:0] motor_2_speed;
    logic signed [MOTOR_W-1:0] motor_3_speed;
  } out_t;

endpackage

>>> rtl/quadrotor_attitude_pd_mixer.sv
// ----------------------------------------------------------------------------
// quadrotor_attitude_pd_mixer: per-axis PD attitude control with plus mixer
// One axis sample per beat; roll and pitch store a correction, yaw emits the
// four motor speed commands.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one axis sample (in_data). Roll and pitch beats
//    only update the stored correction; a yaw beat yields one out_data beat
//    with the four saturated motor speeds. Axis code 3 is dropped.
//  - cfg_wr_en/cfg_index/cfg_data write the gain, deadband and hover
//    registers; write them only while the block is idle.
//  - A sample is held in the input register while the error, deadband,
//    two gain multiplies, mixing and saturation run combinationally; the
//    motor speeds of a yaw sample are then loaded into the output register.
//  - Throughput: one beat per cycle while no yaw sample waits on a held
//    out_data beat, set by the single pass between input and output registers.
//  - Stall: a held out_data beat only blocks a waiting yaw sample and the
//    input behind it; roll and pitch samples in the input register still flow.
//  - Reset (rst_n low, synchronous) empties both registers, zeroes the roll
//    and pitch corrections and loads the default register values.
// ----------------------------------------------------------------------------
module quadrotor_attitude_pd_mixer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  qapm_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output qapm_pkg::out_t                        out_data,
  input  logic                                  cfg_wr_en,
  input  logic [qapm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qapm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int ERR_W    = qapm_pkg::ERR_W;
  localparam int CORR_W   = qapm_pkg::CORR_W;
  localparam int FORCE_W  = qapm_pkg::FORCE_W;
  localparam int MIX_W    = qapm_pkg::MIX_W;
  localparam int MOTOR_W  = qapm_pkg::MOTOR_W;
  localparam int GAIN_W   = qapm_pkg::GAIN_W;

  // configuration registers
  logic [GAIN_W-1:0]               roll_kp_r, roll_kd_r;
  logic [GAIN_W-1:0]               pitch_kp_r, pitch_kd_r;
  logic [GAIN_W-1:0]               yaw_kp_r, yaw_kd_r;
  logic [qapm_pkg::DEADBAND_W-1:0] deadband_r;
  logic [qapm_pkg::HOVER_W-1:0]    hover_r;

  // state
  logic signed [CORR_W-1:0]        roll_corr_r, pitch_corr_r;

  // input stage and output register
  logic                            s1_valid_r;
  qapm_pkg::in_t                   s1_data_r;
  logic                            out_valid_r;
  qapm_pkg::out_t                  out_data_r;
  qapm_pkg::out_t                  out_data_nxt;

  logic                            s1_is_yaw;
  logic                            out_free;
  logic                            s1_fire;
  logic                            out_load;

  logic [GAIN_W-1:0]               kp_sel, kd_sel;
  logic signed [ERR_W-1:0]         ang_err, rate_err;
  logic signed [ERR_W-1:0]         ang_band, rate_band;
  logic signed [CORR_W-1:0]        ang_prod, rate_prod, corr;
  logic signed [FORCE_W-1:0]       force_val;
  logic signed [MIX_W-1:0]         mix0, mix1, mix2, mix3;

  function automatic logic signed [ERR_W-1:0] apply_band(
    input logic signed [ERR_W-1:0]         e,
    input logic [qapm_pkg::DEADBAND_W-1:0] db
  );
    logic [ERR_W-1:0] mag;
    mag = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
    return (mag < ERR_W'(db)) ? '0 : e;
  endfunction

  function automatic logic signed [MOTOR_W-1:0] sat_motor(
    input logic signed [MIX_W-1:0] v
  );
    logic [MIX_W-MOTOR_W:0] top;
    top = v[MIX_W-1:MOTOR_W-1];
    if (top == '0 || top == '1) begin
      return v[MOTOR_W-1:0];
    end else if (v[MIX_W-1]) begin
      return {1'b1, {(MOTOR_W-1){1'b0}}};
    end else begin
      return {1'b0, {(MOTOR_W-1){1'b1}}};
    end
  endfunction

  // handshake: only a yaw beat needs room in the output register
  assign s1_is_yaw = (s1_data_r.axis == qapm_pkg::AXIS_YAW);
  assign out_free  = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && (!s1_is_yaw || out_free);
  assign out_load  = s1_fire && s1_is_yaw;
  assign in_ready  = !s1_valid_r || s1_fire;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (s1_data_r.axis)
      qapm_pkg::AXIS_ROLL: begin
        kp_sel = roll_kp_r;
        kd_sel = roll_kd_r;
      end
      qapm_pkg::AXIS_PITCH: begin
        kp_sel = pitch_kp_r;
        kd_sel = pitch_kd_r;
      end
      default: begin
        kp_sel = yaw_kp_r;
        kd_sel = yaw_kd_r;
      end
    endcase
  end

  assign ang_err   = ERR_W'(s1_data_r.desired_angle) - ERR_W'(s1_data_r.measured_angle);
  assign rate_err  = ERR_W'(s1_data_r.desired_rate) - ERR_W'(s1_data_r.measured_rate);
  assign ang_band  = apply_band(ang_err, deadband_r);
  assign rate_band = apply_band(rate_err, deadband_r);

  assign ang_prod  = CORR_W'(ang_band) * CORR_W'($signed({1'b0, kp_sel}));
  assign rate_prod = CORR_W'(rate_band) * CORR_W'($signed({1'b0, kd_sel}));
  assign corr      = ang_prod + rate_prod;

  assign force_val = FORCE_W'($signed({2'b00, hover_r})) + FORCE_W'(s1_data_r.thrust_delta);

  assign mix0 = MIX_W'(force_val) - MIX_W'(pitch_corr_r) + MIX_W'(corr);
  assign mix1 = MIX_W'(force_val) - MIX_W'(roll_corr_r)  - MIX_W'(corr);
  assign mix2 = MIX_W'(force_val) + MIX_W'(pitch_corr_r) + MIX_W'(corr);
  assign mix3 = MIX_W'(force_val) + MIX_W'(roll_corr_r)  - MIX_W'(corr);

  always_comb begin
    out_data_nxt.motor_0_speed = sat_motor(mix0);
    out_data_nxt.motor_1_speed = sat_motor(mix1);
    out_data_nxt.motor_2_speed = sat_motor(mix2);
    out_data_nxt.motor_3_speed = sat_motor(mix3);
  end

  // control, configuration and correction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      roll_corr_r  <= '0;
      pitch_corr_r <= '0;
      roll_kp_r    <= qapm_pkg::RST_ROLL_KP;
      roll_kd_r    <= qapm_pkg::RST_ROLL_KD;
      pitch_kp_r   <= qapm_pkg::RST_PITCH_KP;
      pitch_kd_r   <= qapm_pkg::RST_PITCH_KD;
      yaw_kp_r     <= qapm_pkg::RST_YAW_KP;
      yaw_kd_r     <= qapm_pkg::RST_YAW_KD;
      deadband_r   <= qapm_pkg::RST_DEADBAND;
      hover_r      <= qapm_pkg::RST_HOVER;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_fire && s1_data_r.axis == qapm_pkg::AXIS_ROLL) begin
        roll_corr_r <= corr;
      end
      if (s1_fire && s1_data_r.axis == qapm_pkg::AXIS_PITCH) begin
        pitch_corr_r <= corr;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          qapm_pkg::REG_ROLL_KP:  roll_kp_r  <= cfg_data[GAIN_W-1:0];
          qapm_pkg::REG_ROLL_KD:  roll_kd_r  <= cfg_data[GAIN_W-1:0];
          qapm_pkg::REG_PITCH_KP: pitch_kp_r <= cfg_data[GAIN_W-1:0];
          qapm_pkg::REG_PITCH_KD: pitch_kd_r <= cfg_data[GAIN_W-1:0];
          qapm_pkg::REG_YAW_KP:   yaw_kp_r   <= cfg_data[GAIN_W-1:0];
          qapm_pkg::REG_YAW_KD:   yaw_kd_r   <= cfg_data[GAIN_W-1:0];
          qapm_pkg::REG_DEADBAND: deadband_r <= cfg_data[qapm_pkg::DEADBAND_W-1:0];
          qapm_pkg::REG_HOVER:    hover_r    <= cfg_data[qapm_pkg::HOVER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
